@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SPIL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SPIL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SPIL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/spil_pkg.sv @@
`default_nettype none

package spil_pkg;

    localparam int COORD_BITS = 16;
    localparam int CAP_BITS   = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd10;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_READ_OK  = 2'd2;
    localparam logic [1:0] ST_READ_BAD = 2'd3;

    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        logic   gt;
        t_point pt;
    } t_link;

endpackage

`default_nettype wire

@@ rtl/spil_cell.sv @@
`default_nettype none

module spil_cell
    import spil_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_shift_en,
    input  wire         i_occ,
    input  wire         i_at_end,
    input  wire t_point i_new_pt,
    input  wire t_link  i_left,
    output t_link       o_link,
    output logic        o_take_new
);

    t_point r_pt;
    logic   w_gt;

    always_comb begin
        w_gt = i_occ && ((r_pt.x > i_new_pt.x) ||
                         ((r_pt.x == i_new_pt.x) && (r_pt.y > i_new_pt.y)));
        o_take_new = !i_left.gt && (w_gt || i_at_end);
        o_link     = '{gt: w_gt, pt: r_pt};
    end

    // shift up from the left neighbor, or drop the new point in place
    always_ff @(posedge i_clk) begin
        if (i_shift_en) begin
            if (i_left.gt) begin
                r_pt <= i_left.pt;
            end else if (o_take_new) begin
                r_pt <= i_new_pt;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sorted_point_insert_list.sv @@
// Channel | Direction | Handshake                  | Payload
// input   | in        | i_in_valid / o_in_stall    | i_kind i_point_x i_point_y i_read_index
// result  | out       | o_out_valid / i_out_stall  | o_status o_position o_entry_count o_out_x
//         |           |                            | o_out_y
// config  | in        | APB psel/penable/pwrite    | paddr pwdata prdata pready
//
// Unstalled, one item per cycle; on insert every cell compares and shifts in the same cycle.
// The result appears in the cycle after the item is accepted, from an output register.
// A stalled result stalls the input only while that register is occupied and held.
// Reset clears the entry count and sets capacity_limit to 10; no clearing pass.
`default_nettype none

module sorted_point_insert_list
    import spil_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_kind,
    input  wire  signed [COORD_BITS-1:0]      i_point_x,
    input  wire  signed [COORD_BITS-1:0]      i_point_y,
    input  wire  [$clog2(LIST_DEPTH)-1:0]     i_read_index,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [1:0]                        o_status,
    output logic [$clog2(LIST_DEPTH)-1:0]     o_position,
    output logic [$clog2(LIST_DEPTH+1)-1:0]   o_entry_count,
    output logic signed [COORD_BITS-1:0]      o_out_x,
    output logic signed [COORD_BITS-1:0]      o_out_y,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [2:0]                        paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    `include "assert_macros.svh"

    localparam int IW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

    localparam logic [CW-1:0] DEPTH_CNT = CW'(LIST_DEPTH);

    logic [CAP_BITS-1:0]         r_cap;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_out_valid;
    logic [1:0]                  r_status;
    logic [1:0]                  n_status;
    logic [IW-1:0]               r_pos;
    logic [IW-1:0]               n_pos;
    logic [CW-1:0]               r_out_cnt;
    t_point                      r_out_pt;
    t_point                      n_out_pt;

    logic                        w_acc;
    logic                        w_full;
    logic                        w_insert;
    logic                        w_cfg_wr;
    logic [IW-1:0]               w_new_pos;
    t_point                      w_rd_pt;
    t_point                      w_new_pt;
    logic [LIST_DEPTH-1:0]       w_take_new;
    t_link                       w_link [LIST_DEPTH+1];

    assign pready     = 1'b1;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);
    assign w_new_pt   = '{x: i_point_x, y: i_point_y};

    assign w_full   = (CMPW'(r_count) >= CMPW'(r_cap)) || (r_count == DEPTH_CNT);
    assign w_insert = w_acc && (i_kind == KIND_INSERT) && !w_full;

    assign w_link[0] = '{gt: 1'b0, pt: '0};

    for (genvar gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
        spil_cell u_cell (
            .i_clk      (i_clk),
            .i_shift_en (w_insert),
            .i_occ      (r_count > CW'(gi)),
            .i_at_end   (r_count == CW'(gi)),
            .i_new_pt   (w_new_pt),
            .i_left     (w_link[gi]),
            .o_link     (w_link[gi+1]),
            .o_take_new (w_take_new[gi])
        );
    end

    always_comb begin
        w_new_pos = '0;
        w_rd_pt   = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_take_new[i]) begin
                w_new_pos = w_new_pos | IW'(i);
            end
            if ((r_count > CW'(i)) && (i_read_index == IW'(i))) begin
                w_rd_pt = w_rd_pt | w_link[i+1].pt;
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_pos    = '0;
        n_out_pt = '0;
        n_status = ST_FULL;
        unique case (i_kind)
            KIND_INSERT: begin
                if (!w_full) begin
                    n_status = ST_INSERTED;
                    n_pos    = w_new_pos;
                    n_count  = r_count + CW'(1);
                end
            end
            KIND_READ: begin
                n_pos = i_read_index;
                if (CW'(i_read_index) >= r_count) begin
                    n_status = ST_READ_BAD;
                end else begin
                    n_status = ST_READ_OK;
                    n_out_pt = w_rd_pt;
                end
            end
            default: begin
                n_status = ST_FULL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_cap <= pwdata[CAP_BITS-1:0];
            end
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status  <= n_status;
            r_pos     <= n_pos;
            r_out_cnt <= n_count;
            r_out_pt  <= n_out_pt;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_CAPACITY) begin
            prdata = 32'(r_cap);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_pos;
    assign o_entry_count = r_out_cnt;
    assign o_out_x       = r_out_pt.x;
    assign o_out_y       = r_out_pt.y;

    `SPIL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_CNT, "count above depth")
    `SPIL_ASSERT_IMP(a_one_slot, i_clk, i_rst_n, r_count < DEPTH_CNT, $onehot(w_take_new), "insert slot not unique")
    `SPIL_ASSERT_NXT(a_count_inc, i_clk, i_rst_n, w_insert, r_count == $past(r_count) + CW'(1), "count did not advance")
    `SPIL_ASSERT_NXT(a_count_mono, i_clk, i_rst_n, 1'b1, r_count >= $past(r_count), "count decreased")
    `SPIL_ASSERT_NXT(a_result_cnt, i_clk, i_rst_n, w_acc, o_entry_count == r_count, "result count mismatch")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spil_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic                         kind;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [3:0]                   idx;
    } t_list_op;

    typedef struct packed {
        logic [1:0]                   status;
        logic [3:0]                   position;
        logic [4:0]                   entry_count;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
    } t_list_reply;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_kind = 1'b0;
    logic signed [COORD_BITS-1:0] i_point_x = '0;
    logic signed [COORD_BITS-1:0] i_point_y = '0;
    logic [3:0]                   i_read_index = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [1:0]                   o_status;
    logic [3:0]                   o_position;
    logic [4:0]                   o_entry_count;
    logic signed [COORD_BITS-1:0] o_out_x;
    logic signed [COORD_BITS-1:0] o_out_y;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [2:0]                   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    sorted_point_insert_list #(
        .LIST_DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_position   (o_position),
        .o_entry_count(o_entry_count),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    t_list_op    point_ops[$];
    t_list_reply list_replies[$];
    t_point      model_list[DEPTH];
    int          model_count = 0;
    logic [4:0]  model_cap = CAP_RESET;
    int          mismatches = 0;
    bit          idle_on = 1'b1;
    bit          item_taken = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;

    always #10 i_clk = ~i_clk;

    task automatic apply_to_list(input logic kind, input logic signed [COORD_BITS-1:0] x,
                                 input logic signed [COORD_BITS-1:0] y, input logic [3:0] idx);
        t_list_reply r;
        t_point      np;
        int          lim;
        int          i;
        r = '0;
        lim = (model_cap > DEPTH) ? DEPTH : model_cap;
        if (kind == KIND_INSERT) begin
            if (model_count >= lim) begin
                r.status = ST_FULL;
            end else begin
                np.x = x;
                np.y = y;
                i = model_count;
                while (i > 0 && (model_list[i-1].x > np.x ||
                       (model_list[i-1].x == np.x && model_list[i-1].y > np.y))) begin
                    model_list[i] = model_list[i-1];
                    i--;
                end
                model_list[i] = np;
                model_count++;
                r.status = ST_INSERTED;
                r.position = i[3:0];
            end
        end else begin
            r.position = idx;
            if (idx >= model_count) begin
                r.status = ST_READ_BAD;
            end else begin
                r.status = ST_READ_OK;
                r.out_x = model_list[idx].x;
                r.out_y = model_list[idx].y;
            end
        end
        r.entry_count = model_count[4:0];
        list_replies.push_back(r);
    endtask

    always @(negedge i_clk) begin : item_driver
        t_list_op nxt_op;
        if (i_rst_n && (!i_in_valid || item_taken)) begin
            item_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (point_ops.size() != 0) begin
                nxt_op = point_ops.pop_front();
                i_kind <= nxt_op.kind;
                i_point_x <= nxt_op.x;
                i_point_y <= nxt_op.y;
                i_read_index <= nxt_op.idx;
                i_in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 14);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : reply_monitor
        t_list_reply want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                item_taken = 1'b1;
                apply_to_list(i_kind, i_point_x, i_point_y, i_read_index);
            end
            if (o_out_valid && !i_out_stall) begin
                if (list_replies.size() == 0) begin
                    $error("unexpected result item: status %0d position %0d", o_status,
                           o_position);
                    mismatches++;
                end else begin
                    want = list_replies.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, o_position);
                        mismatches++;
                    end
                    if (o_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               o_entry_count);
                        mismatches++;
                    end
                    if (o_out_x !== want.out_x) begin
                        $error("out_x: expected %0d, got %0d", want.out_x, o_out_x);
                        mismatches++;
                    end
                    if (o_out_y !== want.out_y) begin
                        $error("out_y: expected %0d, got %0d", want.out_y, o_out_y);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic push_op(input logic kind, input logic signed [COORD_BITS-1:0] x,
                           input logic signed [COORD_BITS-1:0] y, input logic [3:0] idx);
        t_list_op op;
        op.kind = kind;
        op.x = x;
        op.y = y;
        op.idx = idx;
        point_ops.push_back(op);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0: pick_coord = COORD_BITS'($urandom_range(0, 6) - 3);
            1: begin
                case ($urandom_range(0, 3))
                    0: pick_coord = 16'h8000;
                    1: pick_coord = 16'h7FFF;
                    2: pick_coord = 16'hFFFF;
                    default: pick_coord = 16'h0000;
                endcase
            end
            default: pick_coord = COORD_BITS'($urandom());
        endcase
    endfunction

    task automatic queue_random(input int count, input int insert_pct);
        repeat (count) begin
            push_op(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_READ,
                    pick_coord(), pick_coord(), 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (point_ops.size() != 0 || i_in_valid || list_replies.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_CAPACITY;
        pwdata <= {27'($urandom()), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        model_cap = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        logic [4:0] phase_caps[10];
        phase_caps = '{5'd4, 5'd13, 5'd17, 5'd1, 5'd31, 5'd16, 5'd0, 5'd0, 5'd0, 5'd0};
        for (int p = 6; p < 10; p++) phase_caps[p] = 5'($urandom_range(0, 31));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, then fill to the reset capacity with extremes and duplicates
        push_op(KIND_READ, 16'sh7FFF, 16'sh8000, 4'd0);
        push_op(KIND_READ, 16'sh0000, 16'shFFFF, 4'd15);
        push_op(KIND_INSERT, 16'sh8000, 16'sh7FFF, 4'd15);
        push_op(KIND_INSERT, 16'sh7FFF, 16'sh8000, 4'd0);
        push_op(KIND_INSERT, 16'sh0000, 16'sh0000, 4'd7);
        push_op(KIND_INSERT, 16'sh0000, 16'sh0000, 4'd8);
        push_op(KIND_INSERT, 16'sh0000, 16'shFFFF, 4'd0);
        push_op(KIND_INSERT, 16'sh0000, 16'sh7FFF, 4'd0);
        push_op(KIND_INSERT, 16'sh8000, 16'sh8000, 4'd0);
        push_op(KIND_INSERT, 16'sh7FFF, 16'sh7FFF, 4'd0);
        push_op(KIND_INSERT, 16'shFFFF, 16'sh0000, 4'd0);
        push_op(KIND_INSERT, 16'sh0000, 16'sh0000, 4'd0);
        push_op(KIND_INSERT, 16'sh0005, 16'sh0005, 4'd0);
        push_op(KIND_READ, 16'sh0000, 16'sh0000, 4'd0);
        push_op(KIND_READ, 16'sh0000, 16'sh0000, 4'd9);
        push_op(KIND_READ, 16'sh0000, 16'sh0000, 4'd10);
        drain();

        // capacity zero, also below the current count
        write_capacity(5'd0);
        push_op(KIND_INSERT, 16'sh0001, 16'sh0001, 4'd0);
        push_op(KIND_READ, 16'sh0000, 16'sh0000, 4'd10);
        drain();

        for (int p = 0; p < 10; p++) begin
            idle_on = (p != 9);
            write_capacity(phase_caps[p]);
            queue_random(200, 30);
            drain();
        end

        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/spil_pkg.sv
rtl/spil_cell.sv
rtl/sorted_point_insert_list.sv
sim/tb.sv
